@@ rtl/rau_pkg.sv @@
`default_nettype none
package rau_pkg;
   localparam int NUM_WIDTH = 33;
   localparam int DEN_WIDTH = 31;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_GCD,
      ST_DIV,
      ST_DONE
   } state_type;

   // control from the sequencer to the cell row
   typedef struct packed {
      logic load;   // capture dividend and divisor into the row
      logic shift;  // advance one bit of restoring division
   } cell_ctl_type;
endpackage
`default_nettype wire

@@ rtl/rau_cell.sv @@
`default_nettype none
// One bit cell of a shift/subtract divider row. Each cell holds one bit of the
// partial remainder and one bit of the divisor; the borrow ripples along the row.
module rau_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rau_pkg::cell_ctl_type ctl,
   input  wire logic             load_rem,
   input  wire logic             load_dvs,
   input  wire logic             rem_lo,     // bit shifted in from the lower neighbour
   input  wire logic             borrow_in,
   input  wire logic             take,       // row-wide: subtraction succeeded
   output logic                  rem_out,    // current remainder bit
   output logic                  borrow_out
);
   import rau_pkg::*;
   logic rem_ff, rem_in, dvs_ff, dvs_in, diff;

   assign diff       = rem_lo ^ dvs_ff ^ borrow_in;
   assign borrow_out = (~rem_lo & (dvs_ff | borrow_in)) | (dvs_ff & borrow_in);
   assign rem_out    = rem_ff;

   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (ctl.load) begin
         rem_in = load_rem;
         dvs_in = load_dvs;
      end else if (ctl.shift) begin
         rem_in = take ? diff : rem_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 1'b0;
         dvs_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         dvs_ff <= dvs_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/rau_divrow.sv @@
`default_nettype none
// Restoring divider built as a row of bit cells. One quotient bit per cycle of
// ctl.shift: the dividend shifts in at the bottom; each shift tries remainder - divisor.
module rau_divrow #(
   parameter int W = 34
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rau_pkg::cell_ctl_type ctl,
   input  wire logic [W-1:0]  dividend,
   input  wire logic [W-1:0]  divisor,
   output logic [W-1:0]       quotient,
   output logic [W-1:0]       remainder
);
   import rau_pkg::*;
   logic [W-1:0] rem;
   logic [W:0]   borrow;
   logic [W-1:0] shin;
   logic [W-1:0] quo_ff, quo_in;
   logic         take;

   // extra top bit of the remainder; cleared on load and on every shift, so it stays zero
   logic top_ff, top_in;
   assign borrow[0] = 1'b0;
   assign shin      = {rem[W-2:0], quo_ff[W-1]};
   assign take      = top_ff | rem[W-1] | ~borrow[W];

   for (genvar i = 0; i < W; i++) begin : g_cell
      rau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .load_rem  (1'b0),
         .load_dvs  (divisor[i]),
         .rem_lo    (shin[i]),
         .borrow_in (borrow[i]),
         .take      (take),
         .rem_out   (rem[i]),
         .borrow_out(borrow[i+1])
      );
   end

   always_comb begin
      quo_in = quo_ff;
      top_in = top_ff;
      if (ctl.load) begin
         quo_in = dividend;
         top_in = 1'b0;
      end else if (ctl.shift) begin
         quo_in = {quo_ff[W-2:0], take};
         top_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff <= '0;
         top_ff <= 1'b0;
      end else begin
         quo_ff <= quo_in;
         top_ff <= top_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem;
endmodule
`default_nettype wire

@@ rtl/rational_arithmetic_unit.sv @@
`default_nettype none
// Rational arithmetic unit: forms a/b op c/d (add, subtract, multiply, divide)
// and reduces it by gcd. One transaction at a time. The cross products are taken
// with the request and combined in the ST_MUL state. Then come the Euclid steps,
// each a full pass of the bit-serial divider row: load, W shifts and read
// (W = 2*OPERAND_WIDTH+2). Two more passes divide numerator and denominator by
// the gcd, and the ST_DONE state raises rsp_valid. A zero-denominator or zero-divisor
// error is valid the cycle after acceptance. A result that waits holds off the next request.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_first_numerator,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_first_denominator,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_second_numerator,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_second_denominator,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [rau_pkg::NUM_WIDTH-1:0] rsp_result_numerator,
   output logic [rau_pkg::DEN_WIDTH-1:0]      rsp_result_denominator,
   output logic                               rsp_error_flag
);
   import rau_pkg::*;
   localparam int MW   = 2 * OPERAND_WIDTH;
   localparam int W    = MW + 2;
   localparam int LAST = W + 1;
   localparam int CW   = $clog2(W + 2);

   state_type    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] mb_ff, mc_ff, md_ff;
   logic [OPERAND_WIDTH-1:0] ma, mb, mc, md;
   logic         sa, sb, sc, sd;
   cmd_type      cmd_ff;
   logic         n1_ff, n2_ff, err;
   logic [MW-1:0] t1_ff, t2_ff;
   logic [W-1:0] num_ff, den_ff, x_ff, y_ff, g_ff, qn_ff;
   logic         neg_ff, phase_ff;
   logic [W-1:0] dvd, dvs, quo, rem;
   cell_ctl_type ctl;
   logic         out_v_ff;
   logic [NUM_WIDTH-1:0] out_n_ff;
   logic [DEN_WIDTH-1:0] out_d_ff;
   logic         out_e_ff;

   assign sa = req_first_numerator[OPERAND_WIDTH-1];
   assign sb = req_first_denominator[OPERAND_WIDTH-1];
   assign sc = req_second_numerator[OPERAND_WIDTH-1];
   assign sd = req_second_denominator[OPERAND_WIDTH-1];
   assign ma = sa ? -req_first_numerator : req_first_numerator;
   assign mb = sb ? -req_first_denominator : req_first_denominator;
   assign mc = sc ? -req_second_numerator : req_second_numerator;
   assign md = sd ? -req_second_denominator : req_second_denominator;
   assign err = (mb == '0) || (md == '0) || (cmd_type'(req_cmd) == CMD_DIV && mc == '0);

   assign req_ready = (state_ff == ST_IDLE) && !out_v_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_ready && !err) state_in = ST_MUL;
         ST_MUL:  begin
            state_in = ST_GCD;
            cnt_in   = '0;
         end
         ST_GCD: begin
            if (cnt_ff == CW'(LAST)) begin
               cnt_in = '0;
               if (rem == '0) state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CW'(LAST)) begin
               cnt_in = '0;
               if (phase_ff) state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // row control: load on count 0, shift on each count up to W, result read at the last count
   always_comb begin
      ctl.load  = 1'b0;
      ctl.shift = 1'b0;
      unique case (state_ff)
         ST_GCD, ST_DIV: begin
            ctl.load  = (cnt_ff == '0);
            ctl.shift = (cnt_ff != '0) && (cnt_ff != CW'(LAST));
         end
         default: ;
      endcase
   end

   // y_ff of zero marks the first Euclid pass: the row takes num and den directly
   always_comb begin
      dvd = x_ff;
      dvs = y_ff;
      if (state_ff == ST_GCD && y_ff == '0) begin
         dvd = num_ff;
         dvs = den_ff;
      end else if (state_ff == ST_DIV) begin
         dvd = phase_ff ? den_ff : num_ff;
         dvs = g_ff;
      end
   end

   rau_divrow #(.W(W)) u_row (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .dividend (dvd),
      .divisor  (dvs),
      .quotient (quo),
      .remainder(rem)
   );

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mb_ff  <= mb;
         mc_ff  <= mc;
         md_ff  <= md;
         cmd_ff <= cmd_type'(req_cmd);
         n1_ff  <= sa ^ sb;
         n2_ff  <= (sc ^ sd) ^ (cmd_type'(req_cmd) == CMD_SUB);
      end
      if (state_ff == ST_IDLE) begin
         t1_ff <= MW'(ma * (cmd_type'(req_cmd) == CMD_MUL ? mc : md));
         t2_ff <= MW'(mc * mb);
      end
      if (state_ff == ST_MUL) begin
         unique case (cmd_ff)
            CMD_MUL: begin
               num_ff <= W'(t1_ff);
               den_ff <= W'(mb_ff * md_ff);
               neg_ff <= n1_ff ^ n2_ff;
            end
            CMD_DIV: begin
               num_ff <= W'(t1_ff);
               den_ff <= W'(mb_ff * mc_ff);
               neg_ff <= n1_ff ^ n2_ff;
            end
            default: begin
               den_ff <= W'(mb_ff * md_ff);
               if (n1_ff == n2_ff) begin
                  num_ff <= W'(t1_ff) + W'(t2_ff);
                  neg_ff <= n1_ff;
               end else if (t1_ff >= t2_ff) begin
                  num_ff <= W'(t1_ff - t2_ff);
                  neg_ff <= n1_ff;
               end else begin
                  num_ff <= W'(t2_ff - t1_ff);
                  neg_ff <= n2_ff;
               end
            end
         endcase
      end
      if (state_ff == ST_MUL) begin
         x_ff <= '0;
         y_ff <= '0;
         phase_ff <= 1'b0;
      end
      if (state_ff == ST_GCD && cnt_ff == '0 && y_ff == '0) begin
         x_ff <= num_ff;
         y_ff <= den_ff;
      end
      if (state_ff == ST_GCD && cnt_ff == CW'(LAST)) begin
         x_ff <= y_ff;
         y_ff <= rem;
         if (rem == '0) g_ff <= y_ff;
      end
      if (state_ff == ST_DIV && cnt_ff == CW'(LAST)) begin
         phase_ff <= 1'b1;
         if (!phase_ff) qn_ff <= quo;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (req_valid && req_ready && err) begin
         out_v_ff <= 1'b1;
      end else if (state_ff == ST_DONE) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && err) begin
         out_n_ff <= '0;
         out_d_ff <= '0;
         out_e_ff <= 1'b1;
      end else if (state_ff == ST_DIV && cnt_ff == CW'(LAST) && phase_ff) begin
         out_n_ff <= (neg_ff && qn_ff != '0) ? -NUM_WIDTH'(qn_ff) : NUM_WIDTH'(qn_ff);
         out_d_ff <= DEN_WIDTH'(quo);
         out_e_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign rsp_valid              = out_v_ff;
   assign rsp_result_numerator   = out_n_ff;
   assign rsp_result_denominator = out_d_ff;
   assign rsp_error_flag         = out_e_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid) else $error("result lost");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_flag) |-> (rsp_result_denominator == '0))
      else $error("error result not zero");
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_error_flag) |-> (rsp_result_denominator != '0))
      else $error("zero denominator on good result");
endmodule
`default_nettype wire
